// ===== rtl/core/lgge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid engine package
// Shared sizes, codes and types of the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

  // Grid capacity and derived widths.
  localparam int COLS   = 64;
  localparam int ROWS   = 64;
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  // Size registers are 7 bits wide; they hold 0..127, taken as 1..COLS or 1..ROWS.
  localparam int SIZE_W = 7;

  // Rule B3/S23 neighbor counts.
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  // One stored row of the grid.
  typedef logic [COLS-1:0] row_t;

  // Operation codes of an input item; code 3 does nothing.
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_OP_ROW,
    S_RESP,
    S_ADV_INIT,
    S_ADV_CUR,
    S_ADV_FETCH,
    S_ADV_BELOW,
    S_ADV_CELL,
    S_ADV_WRITE
  } state_t;

  // 3x3 window around one cell: bit 2 is the left column, bit 0 the right.
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] mid;
    logic [2:0] below;
  } nbhd_t;

endpackage

// ===== rtl/core/life_grid_generation_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine
// Bounded grid of one-bit cells with cell write, cell read and a B3/S23
// generation advance swept one cell per cycle through a shared rule unit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_ready   in_operation, in_col, in_row, in_alive
//   out_      output     out_valid/out_ready out_cell_value
//   cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// A write or read inside the active area reads its row and then goes to the
// result state; one outside the area, or the unused code, goes there at once.
// An advance sweeps the active rows in order; the single rule unit evaluates
// one cell per cycle, and each row adds a fetch, a below-row load and a write.
// No new item is taken while an item is in work; one result may wait in the
// output register while the next item is taken.
// Reset is synchronous; the grid reads as dead right after reset.
module life_grid_generation_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_operation,
  input  logic [5:0]                      in_col,
  input  logic [5:0]                      in_row,
  input  logic                            in_alive,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_cell_value,
  // Configuration port
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [lgge_pkg::SIZE_W-1:0]     cfg_wdata
);

  localparam int COL_W  = lgge_pkg::COL_W;
  localparam int ROW_W  = lgge_pkg::ROW_W;
  localparam int SIZE_W = lgge_pkg::SIZE_W;
  localparam int COLS   = lgge_pkg::COLS;

  lgge_pkg::state_t    state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [COL_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic                alive_r, alive_nxt;
  logic                res_val_r, res_val_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_cell_value_r, out_cell_value_nxt;
  logic [SIZE_W-1:0]   grid_width_r, grid_height_r;
  lgge_pkg::row_t      above_r, above_nxt;
  lgge_pkg::row_t      cur_r, cur_nxt;
  lgge_pkg::row_t      below_r, below_nxt;
  lgge_pkg::row_t      next_row_r, next_row_nxt;

  logic [SIZE_W-1:0]   w_eff, h_eff;
  logic                in_inside;
  logic                last_col, last_row, below_in_grid;
  logic [COL_W-1:0]    col_left, col_right;
  logic                has_left, has_right;
  lgge_pkg::nbhd_t     nb;
  logic                cell_next;
  lgge_pkg::row_t      merged_row, bit_mask;

  logic                mem_re, mem_we;
  logic [ROW_W-1:0]    mem_raddr, mem_waddr;
  lgge_pkg::row_t      mem_rdata, mem_wdata;

  // Active size: zero counts as one, oversize saturates to the capacity.
  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = SIZE_W'(1);
    end else if (grid_width_r > SIZE_W'(COLS)) begin
      w_eff = SIZE_W'(COLS);
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r == '0) begin
      h_eff = SIZE_W'(1);
    end else if (grid_height_r > SIZE_W'(lgge_pkg::ROWS)) begin
      h_eff = SIZE_W'(lgge_pkg::ROWS);
    end else begin
      h_eff = grid_height_r;
    end
  end

  // Position checks against the active area.
  assign in_inside     = (SIZE_W'(in_col) < w_eff) && (SIZE_W'(in_row) < h_eff);
  assign last_col      = (SIZE_W'(col_cnt_r) + SIZE_W'(1)) == w_eff;
  assign last_row      = (SIZE_W'(row_cnt_r) + SIZE_W'(1)) == h_eff;
  assign below_in_grid = (SIZE_W'(row_cnt_r) + SIZE_W'(1)) < h_eff;

  // Window around the swept cell; columns outside the area are dead.
  assign col_left  = col_cnt_r - COL_W'(1);
  assign col_right = col_cnt_r + COL_W'(1);
  assign has_left  = (col_cnt_r != '0);
  assign has_right = (SIZE_W'(col_cnt_r) + SIZE_W'(1)) < w_eff;

  always_comb begin
    nb.above = {above_r[col_left] & has_left, above_r[col_cnt_r],
                above_r[col_right] & has_right};
    nb.mid   = {cur_r[col_left] & has_left, cur_r[col_cnt_r],
                cur_r[col_right] & has_right};
    nb.below = {below_r[col_left] & has_left, below_r[col_cnt_r],
                below_r[col_right] & has_right};
  end

  lgge_cell_rule u_rule (
    .nb         (nb),
    .alive_next (cell_next)
  );

  // New row inside the active width, old contents beyond it.
  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      merged_row[j] = (SIZE_W'(j) < w_eff) ? next_row_r[j] : cur_r[j];
    end
  end

  assign bit_mask = lgge_pkg::row_t'(1) << col_cnt_r;

  lgge_grid_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  assign in_ready = (state_r == lgge_pkg::S_IDLE);

  // Sequencer: next state, datapath loads and memory accesses.
  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    col_cnt_nxt        = col_cnt_r;
    row_cnt_nxt        = row_cnt_r;
    alive_nxt          = alive_r;
    res_val_nxt        = res_val_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_cell_value_nxt = out_cell_value_r;
    above_nxt          = above_r;
    cur_nxt            = cur_r;
    below_nxt          = below_r;
    next_row_nxt       = next_row_r;
    mem_re             = 1'b0;
    mem_raddr          = row_cnt_r;
    mem_we             = 1'b0;
    mem_waddr          = row_cnt_r;
    mem_wdata          = merged_row;

    unique case (state_r)
      lgge_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_operation;
          col_cnt_nxt = in_col;
          row_cnt_nxt = in_row;
          alive_nxt   = in_alive;
          res_val_nxt = 1'b0;
          if (in_operation == lgge_pkg::OP_ADVANCE) begin
            state_nxt = lgge_pkg::S_ADV_INIT;
          end else if (in_inside && ((in_operation == lgge_pkg::OP_WRITE) ||
                                     (in_operation == lgge_pkg::OP_READ))) begin
            mem_re    = 1'b1;
            mem_raddr = in_row;
            state_nxt = lgge_pkg::S_OP_ROW;
          end else begin
            state_nxt = lgge_pkg::S_RESP;
          end
        end
      end

      // Row of the addressed cell is here: modify and write, or pick the bit.
      lgge_pkg::S_OP_ROW: begin
        if (op_r == lgge_pkg::OP_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = (mem_rdata & ~bit_mask) | (alive_r ? bit_mask : '0);
        end else begin
          res_val_nxt = mem_rdata[col_cnt_r];
        end
        state_nxt = lgge_pkg::S_RESP;
      end

      // Hand the result to the output register once it is free.
      lgge_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_cell_value_nxt = res_val_r;
          state_nxt          = lgge_pkg::S_IDLE;
        end
      end

      lgge_pkg::S_ADV_INIT: begin
        above_nxt   = '0;
        row_cnt_nxt = '0;
        mem_re      = 1'b1;
        mem_raddr   = '0;
        state_nxt   = lgge_pkg::S_ADV_CUR;
      end

      lgge_pkg::S_ADV_CUR: begin
        cur_nxt   = mem_rdata;
        state_nxt = lgge_pkg::S_ADV_FETCH;
      end

      lgge_pkg::S_ADV_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = row_cnt_r + ROW_W'(1);
        state_nxt = lgge_pkg::S_ADV_BELOW;
      end

      // Rows past the active height are dead.
      lgge_pkg::S_ADV_BELOW: begin
        below_nxt   = below_in_grid ? mem_rdata : '0;
        col_cnt_nxt = '0;
        state_nxt   = lgge_pkg::S_ADV_CELL;
      end

      // One cell per cycle through the rule unit.
      lgge_pkg::S_ADV_CELL: begin
        next_row_nxt[col_cnt_r] = cell_next;
        if (last_col) begin
          state_nxt = lgge_pkg::S_ADV_WRITE;
        end else begin
          col_cnt_nxt = col_cnt_r + COL_W'(1);
        end
      end

      // Old rows stay in the window, so the new row can be written at once.
      lgge_pkg::S_ADV_WRITE: begin
        mem_we    = 1'b1;
        above_nxt = cur_r;
        cur_nxt   = below_r;
        if (last_row) begin
          state_nxt = lgge_pkg::S_RESP;
        end else begin
          row_cnt_nxt = row_cnt_r + ROW_W'(1);
          state_nxt   = lgge_pkg::S_ADV_FETCH;
        end
      end

      default: begin
        state_nxt = lgge_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgge_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= SIZE_W'(COLS);
      grid_height_r <= SIZE_W'(lgge_pkg::ROWS);
    end else if (cfg_we) begin
      if (cfg_index == lgge_pkg::REG_GRID_WIDTH) begin
        grid_width_r <= cfg_wdata;
      end
      if (cfg_index == lgge_pkg::REG_GRID_HEIGHT) begin
        grid_height_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    col_cnt_r        <= col_cnt_nxt;
    row_cnt_r        <= row_cnt_nxt;
    alive_r          <= alive_nxt;
    res_val_r        <= res_val_nxt;
    out_cell_value_r <= out_cell_value_nxt;
    above_r          <= above_nxt;
    cur_r            <= cur_nxt;
    below_r          <= below_nxt;
    next_row_r       <= next_row_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_value_r;

  // An accepted item keeps the input closed in the following cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  // The store is never written while the sequencer is idle.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgge_pkg::S_IDLE) |-> !mem_we)
    else $error("grid write while idle");

  // The swept column stays inside the active width.
  a_sweep_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lgge_pkg::S_ADV_CELL) |-> (SIZE_W'(col_cnt_r) < w_eff))
    else $error("sweep column beyond active width");

  // A result appears only from the result state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lgge_pkg::S_RESP))
    else $error("result not issued by the result state");

endmodule

// ===== rtl/core/lgge_cell_rule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life cell rule unit
// Counts the eight neighbors of one cell and applies rule B3/S23.
// ----------------------------------------------------------------------------
module lgge_cell_rule (
  input  lgge_pkg::nbhd_t nb,
  output logic            alive_next
);

  logic [3:0] count;

  // Sum the eight neighbors; the center cell is left out.
  assign count = 4'(nb.above[2]) + 4'(nb.above[1]) + 4'(nb.above[0])
               + 4'(nb.mid[2])                    + 4'(nb.mid[0])
               + 4'(nb.below[2]) + 4'(nb.below[1]) + 4'(nb.below[0]);

  // A dead cell is born at three; a live cell survives at two or three.
  assign alive_next = (count == 4'(lgge_pkg::BIRTH_COUNT)) ||
                      (nb.mid[1] && (count == 4'(lgge_pkg::SURVIVE_COUNT)));

endmodule

// ===== rtl/core/lgge_grid_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid row store
// One row per entry, registered read, one valid bit per row so that the
// whole grid reads as dead after reset.
// ----------------------------------------------------------------------------
module lgge_grid_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [lgge_pkg::ROW_W-1:0]   rd_addr,
  output lgge_pkg::row_t               rd_data,
  input  logic                         wr_en,
  input  logic [lgge_pkg::ROW_W-1:0]   wr_addr,
  input  lgge_pkg::row_t               wr_data
);

  lgge_pkg::row_t            mem [lgge_pkg::ROWS];
  logic [lgge_pkg::ROWS-1:0] row_vld_r;
  lgge_pkg::row_t            rd_data_r;

  // Row array and registered read port; a row never written reads as dead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= row_vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // Valid bits are cleared at reset and set by the first write of a row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/tb_life_grid_generation_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Sends cell write, cell read, advance and unused commands over the input
// channel. A behavioral copy of the grid predicts each result, and every
// result transfer is checked against the oldest prediction. Grid sizes are
// changed between phases, and the idling of each side changes with the phase.
// ----------------------------------------------------------------------------
module tb_life_grid_generation_engine;
  import lgge_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int RAND_CMDS_PER_PHASE = 15;
  localparam int FULL_SIZE_ADVANCE_CAP = 3;
  localparam int TAIL_CYCLES = 20;

  // Code 3 of the operation field has no meaning in the package.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Register indexes that no register answers to.
  localparam logic [1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [1:0] REG_UNUSED_HI = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             alive;
  } cell_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_operation = '0;
  logic [5:0]        in_col = '0;
  logic [5:0]        in_row = '0;
  logic              in_alive = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_cell_value;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // Grid copy and size registers as the block should hold them.
  row_t              life_grid [ROWS];
  logic [SIZE_W-1:0] grid_w_reg = SIZE_W'(COLS);
  logic [SIZE_W-1:0] grid_h_reg = SIZE_W'(ROWS);

  cell_cmd_t pending_cmds [$];
  logic      cell_expect_q [$];
  logic      in_took = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        err_count = 0;
  int        cmd_count = 0;
  int        checked_count = 0;
  int        gen_count = 0;
  int        cycle_count = 0;

  life_grid_generation_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_alive       (in_alive),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A size of zero acts as one, and a size above the capacity saturates.
  function automatic int active_size(logic [SIZE_W-1:0] v, int cap);
    if (v == 0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  // One B3/S23 generation over the active area; cells outside it keep their
  // values and count as dead neighbors.
  function automatic void advance_generation(int w, int h);
    row_t nxt [ROWS];
    int   n, rr, cc;
    nxt = life_grid;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if (!(dr == 0 && dc == 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
              n += int'(life_grid[rr][cc]);
          end
        end
        nxt[r][c] = (n == BIRTH_COUNT) || (life_grid[r][c] && n == SURVIVE_COUNT);
      end
    end
    life_grid = nxt;
  endfunction

  // Applies one accepted command to the grid copy and returns its cell value.
  function automatic logic apply_cell_cmd(cell_cmd_t cmd);
    int   w, h;
    logic in_area;
    w = active_size(grid_w_reg, COLS);
    h = active_size(grid_h_reg, ROWS);
    in_area = (int'(cmd.col) < w) && (int'(cmd.row) < h);
    case (cmd.op)
      OP_WRITE: begin
        if (in_area) life_grid[cmd.row][cmd.col] = cmd.alive;
      end
      OP_READ: begin
        if (in_area) return life_grid[cmd.row][cmd.col];
      end
      OP_ADVANCE: begin
        advance_generation(w, h);
        gen_count++;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void queue_cmd(logic [1:0] op, int col, int row, logic alive);
    cell_cmd_t cmd;
    cmd.op = op;
    cmd.col = col[COL_W-1:0];
    cmd.row = row[ROW_W-1:0];
    cmd.alive = alive;
    pending_cmds.push_back(cmd);
  endfunction

  // Random coordinate inside the active size; large grids lean toward the
  // far border half the time so that edge cells see activity.
  function automatic int pick_coord(int size);
    if (size > 16 && $urandom_range(1) == 1) return size - 1 - $urandom_range(7);
    return $urandom_range(size - 1);
  endfunction

  // Register write, only issued while no command is in flight.
  task automatic write_reg(logic [1:0] idx, logic [SIZE_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_GRID_WIDTH) grid_w_reg = data;
    else if (idx == REG_GRID_HEIGHT) grid_h_reg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every queued command is sent and every result has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (!(pending_cmds.size() == 0 && !in_valid && cell_expect_q.size() == 0));
  endtask

  // Driver: presents queued commands and randomizes the result-side ready.
  always @(negedge clk) begin : drive_cmds
    cell_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_operation <= cmd.op;
        in_col <= cmd.col;
        in_row <= cmd.row;
        in_alive <= cmd.alive;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predicts on each command transfer and checks each result transfer.
  always @(posedge clk) begin : watch_channels
    cell_cmd_t cmd;
    logic      want;
    if (rst_n) begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        cmd.op = in_operation;
        cmd.col = in_col;
        cmd.row = in_row;
        cmd.alive = in_alive;
        cell_expect_q.push_back(apply_cell_cmd(cmd));
        cmd_count++;
      end
      if (out_valid && out_ready) begin
        if (cell_expect_q.size() == 0) begin
          $error("result transfer with no command outstanding: cell_value %0b",
                 out_cell_value);
          err_count++;
        end else begin
          want = cell_expect_q.pop_front();
          checked_count++;
          if (out_cell_value !== want) begin
            $error("cell_value mismatch: expected %0b, got %0b", want, out_cell_value);
            err_count++;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_life_grid_generation_engine: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int w, h, adv_left, pick, wdat, hdat;
    for (int r = 0; r < ROWS; r++) life_grid[r] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the grid reads dead after reset, corners, the unused code,
    // a blinker at full size and an isolated cell dying off.
    queue_cmd(OP_READ, 0, 0, 1'b0);
    queue_cmd(OP_READ, 63, 63, 1'b0);
    queue_cmd(OP_WRITE, 63, 63, 1'b1);
    queue_cmd(OP_WRITE, 0, 0, 1'b1);
    queue_cmd(OP_WRITE, 63, 0, 1'b1);
    queue_cmd(OP_READ, 63, 63, 1'b0);
    queue_cmd(OP_UNUSED, 63, 63, 1'b1);
    queue_cmd(OP_WRITE, 11, 10, 1'b1);
    queue_cmd(OP_WRITE, 12, 10, 1'b1);
    queue_cmd(OP_WRITE, 13, 10, 1'b1);
    queue_cmd(OP_WRITE, 0, 0, 1'b0);
    queue_cmd(OP_READ, 0, 0, 1'b0);
    queue_cmd(OP_ADVANCE, 0, 0, 1'b0);
    queue_cmd(OP_READ, 12, 9, 1'b0);
    queue_cmd(OP_READ, 11, 10, 1'b0);
    queue_cmd(OP_READ, 63, 63, 1'b0);
    wait_drained();

    // Directed: unknown indexes change nothing; a zero width and an oversized
    // height give a one-column grid; stored cells outside stay hidden.
    write_reg(REG_UNUSED_LO, SIZE_W'(2));
    write_reg(REG_UNUSED_HI, '0);
    write_reg(REG_GRID_WIDTH, '0);
    write_reg(REG_GRID_HEIGHT, '1);
    queue_cmd(OP_WRITE, 5, 5, 1'b1);
    queue_cmd(OP_READ, 12, 10, 1'b0);
    queue_cmd(OP_WRITE, 0, 20, 1'b1);
    queue_cmd(OP_WRITE, 0, 21, 1'b1);
    queue_cmd(OP_WRITE, 0, 22, 1'b1);
    queue_cmd(OP_ADVANCE, 0, 0, 1'b0);
    queue_cmd(OP_READ, 0, 21, 1'b0);
    queue_cmd(OP_READ, 0, 20, 1'b0);
    wait_drained();

    // Growing back to full size shows the cells that were kept outside.
    write_reg(REG_GRID_WIDTH, SIZE_W'(COLS));
    queue_cmd(OP_READ, 12, 10, 1'b0);
    queue_cmd(OP_READ, 5, 5, 1'b0);
    wait_drained();

    // Random phases: sizes change per phase, idling cycles through its modes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 3) begin
        wdat = COLS;
        hdat = ROWS;
      end else if (ph == 6) begin
        wdat = 127;
        hdat = 0;
      end else if (ph == 5) begin
        wdat = 3;
        hdat = ROWS;
      end else begin
        wdat = $urandom_range(1, 12);
        hdat = $urandom_range(1, 12);
      end
      write_reg(REG_GRID_WIDTH, SIZE_W'(wdat));
      write_reg(REG_GRID_HEIGHT, SIZE_W'(hdat));
      w = active_size(grid_w_reg, COLS);
      h = active_size(grid_h_reg, ROWS);
      adv_left = (w * h > 1024) ? FULL_SIZE_ADVANCE_CAP : RAND_CMDS_PER_PHASE;

      for (int i = 0; i < RAND_CMDS_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          queue_cmd(OP_WRITE, pick_coord(w), pick_coord(h), $urandom_range(99) < 60);
        end else if (pick < 72 || (pick < 88 && adv_left == 0)) begin
          queue_cmd(OP_READ, pick_coord(w), pick_coord(h), 1'($urandom_range(1)));
        end else if (pick < 88) begin
          queue_cmd(OP_ADVANCE, $urandom_range(63), $urandom_range(63),
                    1'($urandom_range(1)));
          adv_left--;
        end else if (pick < 94) begin
          queue_cmd(OP_UNUSED, $urandom_range(63), $urandom_range(63),
                    1'($urandom_range(1)));
        end else begin
          // Anywhere in the field range, mostly outside a small grid.
          queue_cmd($urandom_range(1) ? OP_WRITE : OP_READ, $urandom_range(63),
                    $urandom_range(63), 1'($urandom_range(1)));
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d commands with %0d generations advanced,", cmd_count,
             gen_count);
    $display("%0d results compared over %0d random sizing phases.", checked_count,
             RAND_PHASES);
    if (err_count == 0 && cell_expect_q.size() == 0) begin
      $display("tb_life_grid_generation_engine: clean");
    end else begin
      $display("tb_life_grid_generation_engine: errors");
    end
    $finish;
  end

endmodule
